// ===== hw/rtl/cilp_pkg.sv =====
// cilp_pkg: shared types and constants of the C integer literal parser.
// Used by cilp_accum, cilp_lexer and c_integer_literal_parser_unit.
package cilp_pkg;

   // Number base of the literal under way
   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2,
      RADIX_OCT = 2'd3
   } radix_type;

   // Result type codes
   localparam logic [1:0] TYPE_INT   = 2'd0;
   localparam logic [1:0] TYPE_UINT  = 2'd1;
   localparam logic [1:0] TYPE_LONG  = 2'd2;
   localparam logic [1:0] TYPE_ULONG = 2'd3;

   // Fixed field widths
   localparam int unsigned CHAR_BITS  = 8;
   localparam int unsigned VALUE_BITS = 64;
   localparam int unsigned TYPE_BITS  = 2;

   // One character handed from the input register to the lexer
   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 first_char;
   } lex_in_type;

endpackage

// ===== hw/rtl/c_integer_literal_parser_unit.sv =====
// c_integer_literal_parser_unit: top level, input register, lexer and result register.
// Depends on cilp_pkg and cilp_lexer.
//
// Usage:
//   req channel: one source character per transfer, tdata = char_code,
//   tuser = first_char (1 starts a new literal; other characters while no
//   literal is open are dropped).
//   rsp channel: one transfer per finished literal, sent when the character
//   after the literal arrives. tdata = {float_follows, literal_length,
//   type_code, literal_value}, zero padded to whole bytes.
//   Throughput: one character per cycle while rsp_tready is high; the lexer
//   state updates once per character.
//   Result path: a result for the character that closes the literal passes
//   the input register, then the result register, before it shows on rsp.
//   Stall: while a result waits on rsp_tready low, one more character is
//   held in the input register, then req_tready drops.
//   Reset: synchronous, clears both registers' valid bits and the lexer,
//   which then waits for a first character.
module c_integer_literal_parser_unit #(
   parameter int unsigned LENGTH_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tuser,   // [0] first_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [((67 + LENGTH_BITS + 7) / 8) * 8 - 1:0] rsp_tdata
      // [63:0] literal_value, [65:64] type_code,
      // [65+LENGTH_BITS:66] literal_length, [66+LENGTH_BITS] float_follows
);

   localparam int unsigned LEN_LSB   = 66;
   localparam int unsigned FLOAT_BIT = 66 + LENGTH_BITS;

   logic                   in_valid_ff, in_valid_in;
   cilp_pkg::lex_in_type   in_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [63:0]            value_ff;
   logic [1:0]             type_ff;
   logic [LENGTH_BITS-1:0] length_ff;
   logic                   float_ff;

   logic                   step;
   logic                   emit;
   logic [63:0]            res_value;
   logic [1:0]             res_type;
   logic [LENGTH_BITS-1:0] res_length;
   logic                   res_float;

   // Lexer takes a character when the result register has room
   assign step        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? emit : (out_valid_ff && !rsp_tready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_ff.char_code <= req_tdata;
         in_ff.first_char <= req_tuser;
      end
   end

   cilp_lexer #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_lexer (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .lex_in     (in_ff),
      .emit       (emit),
      .res_value  (res_value),
      .res_type   (res_type),
      .res_length (res_length),
      .res_float  (res_float)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step && emit) begin
         value_ff  <= res_value;
         type_ff   <= res_type;
         length_ff <= res_length;
         float_ff  <= res_float;
      end
   end

   // Pack result transfer
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[63:0] = value_ff;
      rsp_tdata[65:64] = type_ff;
      rsp_tdata[LEN_LSB +: LENGTH_BITS] = length_ff;
      rsp_tdata[FLOAT_BIT] = float_ff;
   end
   assign rsp_tvalid = out_valid_ff;

   // Input side only stalls behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without a blocked result");

   // An empty literal is always int zero
   a_empty_literal: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (length_ff == '0)) |-> (value_ff == '0 && type_ff == cilp_pkg::TYPE_INT))
      else $error("empty literal with nonzero value or type");

   // A result is only loaded when the lexer steps
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (!step && !(out_valid_ff && !rsp_tready)) |=> !rsp_tvalid)
      else $error("result appeared without a lexer step");

endmodule

// ===== hw/rtl/cilp_accum.sv =====
// cilp_accum: one digit step of the accumulator, value * base + digit,
// saturating to all ones on overflow. Depends on cilp_pkg.
module cilp_accum (
   input  logic [63:0]       acc,
   input  cilp_pkg::radix_type radix,
   input  logic [3:0]        digit,
   output logic [63:0]       acc_next
);

   logic [67:0] wide;
   logic [67:0] acc_ext;

   assign acc_ext = {4'b0, acc};

   // Shift-and-add product, one extra nibble catches the carry out
   always_comb begin
      case (radix)
         cilp_pkg::RADIX_HEX: wide = (acc_ext << 4) + {64'b0, digit};
         cilp_pkg::RADIX_BIN: wide = (acc_ext << 1) + {64'b0, digit};
         cilp_pkg::RADIX_OCT: wide = (acc_ext << 3) + {64'b0, digit};
         default:             wide = (acc_ext << 3) + (acc_ext << 1) + {64'b0, digit};
      endcase
   end

   // Any bit above the word means overflow
   assign acc_next = (|wide[67:64]) ? '1 : wide[63:0];

endmodule

// ===== hw/rtl/cilp_lexer.sv =====
// cilp_lexer: literal state registers and the per-character next-state logic.
// Depends on cilp_pkg and cilp_accum.
module cilp_lexer #(
   parameter int unsigned LENGTH_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  cilp_pkg::lex_in_type   lex_in,
   output logic                   emit,
   output logic [63:0]            res_value,
   output logic [1:0]             res_type,
   output logic [LENGTH_BITS-1:0] res_length,
   output logic                   res_float
);

   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_ZERO   = 8'b0000_0010,
      PH_ZX     = 8'b0000_0100,
      PH_ZB     = 8'b0000_1000,
      PH_DIGITS = 8'b0001_0000,
      PH_SUF1   = 8'b0010_0000,
      PH_SUF2   = 8'b0100_0000,
      PH_DONE   = 8'b1000_0000
   } phase_type;

   phase_type               phase_ff, phase_in;
   cilp_pkg::radix_type     radix_ff, radix_in;
   logic [63:0]             acc_ff, acc_in;
   logic [LENGTH_BITS-1:0]  count_ff, count_in;
   logic [7:0]              suf0_ff, suf0_in;
   logic [7:0]              suf1_ff, suf1_in;
   logic                    long_ff, long_in;
   logic                    uns_ff, uns_in;

   logic [7:0]             c;
   logic [4:0]             dig_cur, dig_hex, dig_bin;
   logic [63:0]            acc_step;
   logic [LENGTH_BITS-1:0] count_inc;
   logic                   do_digits;
   logic [7:0]             emit_char;
   logic                   emit_long, emit_uns;
   cilp_pkg::radix_type    emit_radix;

   // Digit value in a base: {valid, value}
   function automatic logic [4:0] digit_of(input logic [7:0] ch, input cilp_pkg::radix_type rx);
      logic [4:0] d;
      logic [3:0] lim;
      d = 5'b0;
      if (ch >= "0" && ch <= "9") d = {1'b1, 4'(ch - "0")};
      else if (ch >= "a" && ch <= "f") d = {1'b1, 4'(ch - "a" + 8'd10)};
      else if (ch >= "A" && ch <= "F") d = {1'b1, 4'(ch - "A" + 8'd10)};
      case (rx)
         cilp_pkg::RADIX_HEX: lim = 4'd15;
         cilp_pkg::RADIX_BIN: lim = 4'd1;
         cilp_pkg::RADIX_OCT: lim = 4'd7;
         default:             lim = 4'd9;
      endcase
      if (d[3:0] > lim) d = 5'b0;
      return d;
   endfunction

   function automatic logic is_l(input logic [7:0] ch);
      return (ch == "L") || (ch == "l");
   endfunction

   function automatic logic is_u(input logic [7:0] ch);
      return (ch == "U") || (ch == "u");
   endfunction

   // C type rules: decimal literals never become unsigned without a U
   function automatic logic [1:0] infer_type(input logic [63:0] v, input cilp_pkg::radix_type rx,
                                             input logic lng, input logic uns);
      logic [1:0] t;
      if (lng && uns) t = cilp_pkg::TYPE_ULONG;
      else if (rx == cilp_pkg::RADIX_DEC) begin
         if (lng)           t = cilp_pkg::TYPE_LONG;
         else if (uns)      t = (|v[63:32]) ? cilp_pkg::TYPE_ULONG : cilp_pkg::TYPE_UINT;
         else               t = (|v[63:31]) ? cilp_pkg::TYPE_LONG : cilp_pkg::TYPE_INT;
      end else begin
         if (lng)           t = v[63] ? cilp_pkg::TYPE_ULONG : cilp_pkg::TYPE_LONG;
         else if (uns)      t = (|v[63:32]) ? cilp_pkg::TYPE_ULONG : cilp_pkg::TYPE_UINT;
         else if (v[63])    t = cilp_pkg::TYPE_ULONG;
         else if (|v[62:32]) t = cilp_pkg::TYPE_LONG;
         else if (v[31])    t = cilp_pkg::TYPE_UINT;
         else               t = cilp_pkg::TYPE_INT;
      end
      return t;
   endfunction

   assign c         = lex_in.char_code;
   assign dig_cur   = digit_of(c, radix_ff);
   assign dig_hex   = digit_of(c, cilp_pkg::RADIX_HEX);
   assign dig_bin   = digit_of(c, cilp_pkg::RADIX_BIN);
   assign count_inc = (&count_ff) ? count_ff : count_ff + 1'b1;

   cilp_accum u_accum (
      .acc      (acc_ff),
      .radix    (radix_ff),
      .digit    (dig_cur[3:0]),
      .acc_next (acc_step)
   );

   // Next state and result for one character
   always_comb begin
      phase_in   = phase_ff;
      radix_in   = radix_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      suf0_in    = suf0_ff;
      suf1_in    = suf1_ff;
      long_in    = long_ff;
      uns_in     = uns_ff;
      emit       = 1'b0;
      do_digits  = 1'b0;
      emit_char  = c;
      emit_long  = long_ff;
      emit_uns   = uns_ff;
      emit_radix = radix_ff;
      res_value  = acc_ff;
      res_length = count_ff;

      if (lex_in.first_char) begin
         // New literal, whatever was under way is dropped
         emit_long  = 1'b0;
         emit_uns   = 1'b0;
         emit_radix = cilp_pkg::RADIX_DEC;
         res_value  = '0;
         res_length = '0;
         acc_in     = '0;
         suf0_in    = '0;
         suf1_in    = '0;
         long_in    = 1'b0;
         uns_in     = 1'b0;
         count_in   = LENGTH_BITS'(1);
         if (c == "0") begin
            radix_in = cilp_pkg::RADIX_OCT;
            phase_in = PH_ZERO;
         end else if (c >= "1" && c <= "9") begin
            radix_in = cilp_pkg::RADIX_DEC;
            acc_in   = {60'b0, c[3:0]};
            phase_in = PH_DIGITS;
         end else begin
            emit = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_ZERO: begin
               if (c == "x" || c == "X") begin
                  suf0_in  = c;
                  phase_in = PH_ZX;
               end else if (c == "b" || c == "B") begin
                  suf0_in  = c;
                  phase_in = PH_ZB;
               end else begin
                  do_digits = 1'b1;
               end
            end
            PH_ZX, PH_ZB: begin
               // Prefix letter kept; without a digit it follows the octal zero
               if ((phase_ff == PH_ZX) ? dig_hex[4] : dig_bin[4]) begin
                  radix_in = (phase_ff == PH_ZX) ? cilp_pkg::RADIX_HEX : cilp_pkg::RADIX_BIN;
                  acc_in   = {60'b0, ((phase_ff == PH_ZX) ? dig_hex[3:0] : dig_bin[3:0])};
                  count_in = LENGTH_BITS'(3);
                  suf0_in  = '0;
                  phase_in = PH_DIGITS;
               end else begin
                  emit      = 1'b1;
                  emit_char = suf0_ff;
               end
            end
            PH_DIGITS: do_digits = 1'b1;
            PH_SUF1: begin
               if (is_l(suf0_ff)) begin
                  if (c == suf0_ff) begin
                     suf1_in  = c;
                     count_in = count_inc;
                     phase_in = PH_SUF2;
                  end else if (is_u(c)) begin
                     long_in  = 1'b1;
                     uns_in   = 1'b1;
                     count_in = count_inc;
                     phase_in = PH_DONE;
                  end else begin
                     emit      = 1'b1;
                     emit_long = 1'b1;
                  end
               end else if (is_l(c)) begin
                  suf1_in  = c;
                  count_in = count_inc;
                  phase_in = PH_SUF2;
               end else begin
                  emit     = 1'b1;
                  emit_uns = 1'b1;
               end
            end
            PH_SUF2: begin
               if (is_l(suf0_ff)) begin
                  if (is_u(c)) begin
                     long_in  = 1'b1;
                     uns_in   = 1'b1;
                     count_in = count_inc;
                     phase_in = PH_DONE;
                  end else begin
                     emit      = 1'b1;
                     emit_long = 1'b1;
                  end
               end else if (c == suf1_ff) begin
                  // U then LL of one case
                  long_in  = 1'b1;
                  uns_in   = 1'b1;
                  count_in = count_inc;
                  phase_in = PH_DONE;
               end else begin
                  emit      = 1'b1;
                  emit_long = 1'b1;
                  emit_uns  = 1'b1;
               end
            end
            PH_DONE: emit = 1'b1;
            default: ;
         endcase
      end

      // Digit or start of a suffix while in the body
      if (do_digits) begin
         phase_in = PH_DIGITS;
         if (dig_cur[4]) begin
            acc_in   = acc_step;
            count_in = count_inc;
         end else if (is_l(c) || is_u(c)) begin
            suf0_in  = c;
            count_in = count_inc;
            phase_in = PH_SUF1;
         end else begin
            emit = 1'b1;
         end
      end

      // A result ends the literal
      if (emit) begin
         phase_in = PH_IDLE;
         radix_in = cilp_pkg::RADIX_DEC;
         acc_in   = '0;
         count_in = '0;
         suf0_in  = '0;
         suf1_in  = '0;
         long_in  = 1'b0;
         uns_in   = 1'b0;
      end
   end

   assign res_type  = infer_type(res_value, emit_radix, emit_long, emit_uns);
   assign res_float = (emit_char == ".") || (emit_char == "e") || (emit_char == "E") ||
                      (emit_char == "f") || (emit_char == "F");

   // Literal state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         radix_ff <= cilp_pkg::RADIX_DEC;
         acc_ff   <= '0;
         count_ff <= '0;
         suf0_ff  <= '0;
         suf1_ff  <= '0;
         long_ff  <= 1'b0;
         uns_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
         suf0_ff  <= suf0_in;
         suf1_ff  <= suf1_in;
         long_ff  <= long_in;
         uns_ff   <= uns_in;
      end
   end

endmodule

// ===== tb/cilp_literal_checker.sv =====
`timescale 1ns / 100ps
// cilp_literal_checker: watches the req and rsp streams of the literal parser,
// predicts each parsed literal and compares it with what comes out on rsp.
// Depends on cilp_pkg for the radix type and the type codes.
module cilp_literal_checker #(
   parameter int unsigned LENGTH_BITS = 12,
   parameter int unsigned RSP_BITS    = ((67 + LENGTH_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] char_code
   input  logic                req_tuser,   // [0] first_char
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RSP_BITS-1:0] rsp_tdata,   // value, type, length, float_follows
   output int                  mismatch_count,
   output int                  pending_literals
);

   // Lexer phases of the predictor
   typedef enum logic [7:0] {
      LEX_IDLE     = 8'b0000_0001,
      LEX_ZERO     = 8'b0000_0010,
      LEX_PREFIX_X = 8'b0000_0100,
      LEX_PREFIX_B = 8'b0000_1000,
      LEX_DIGITS   = 8'b0001_0000,
      LEX_SUFFIX1  = 8'b0010_0000,
      LEX_SUFFIX2  = 8'b0100_0000,
      LEX_DONE     = 8'b1000_0000
   } lex_phase_type;

   typedef struct packed {
      logic                   float_follows;
      logic [LENGTH_BITS-1:0] length;
      logic [1:0]             type_code;
      logic [63:0]            value;
   } literal_type;

   localparam logic [LENGTH_BITS-1:0] LEN_FULL = '1;

   // Predictor state
   lex_phase_type          lex_state;
   cilp_pkg::radix_type    lit_radix;
   logic [63:0]            lit_value;
   logic [LENGTH_BITS-1:0] lit_len;
   logic [15:0]            seen_letters;   // prefix or suffix letters, first in low byte
   logic                   is_long;
   logic                   is_unsigned;

   literal_type expected_literals[$];

   function automatic int digit_value(logic [7:0] c, cilp_pkg::radix_type rx);
      int d;
      d = -1;
      if (c >= "0" && c <= "9") d = c - "0";
      else if (c >= "a" && c <= "f") d = c - "a" + 10;
      else if (c >= "A" && c <= "F") d = c - "A" + 10;
      if (rx == cilp_pkg::RADIX_DEC && d > 9) d = -1;
      if (rx == cilp_pkg::RADIX_OCT && d > 7) d = -1;
      if (rx == cilp_pkg::RADIX_BIN && d > 1) d = -1;
      return d;
   endfunction

   function automatic logic is_l(logic [7:0] c);
      return c == "L" || c == "l";
   endfunction

   function automatic logic is_u(logic [7:0] c);
      return c == "U" || c == "u";
   endfunction

   function automatic void clear_literal();
      lex_state    = LEX_IDLE;
      lit_radix    = cilp_pkg::RADIX_DEC;
      lit_value    = '0;
      lit_len      = '0;
      seen_letters = '0;
      is_long      = 1'b0;
      is_unsigned  = 1'b0;
   endfunction

   function automatic void count_char();
      if (lit_len != LEN_FULL) lit_len++;
   endfunction

   // Multiply-add in the current base, sticking at all ones on overflow
   function automatic void add_digit(int d);
      logic [63:0] base;
      logic [63:0] dv;
      base = (lit_radix == cilp_pkg::RADIX_HEX) ? 64'd16 :
             (lit_radix == cilp_pkg::RADIX_BIN) ? 64'd2 :
             (lit_radix == cilp_pkg::RADIX_OCT) ? 64'd8 : 64'd10;
      dv = 64'(d);
      if (lit_value > (64'hFFFF_FFFF_FFFF_FFFF - dv) / base) lit_value = '1;
      else lit_value = lit_value * base + dv;
   endfunction

   // Decimal literals without a U go int/long, others also try the unsigned types
   function automatic logic [1:0] literal_kind();
      if (is_long && is_unsigned) return cilp_pkg::TYPE_ULONG;
      if (lit_radix == cilp_pkg::RADIX_DEC) begin
         if (is_long) return cilp_pkg::TYPE_LONG;
         if (is_unsigned)
            return (lit_value[63:32] != 0) ? cilp_pkg::TYPE_ULONG : cilp_pkg::TYPE_UINT;
         return (lit_value[63:31] != 0) ? cilp_pkg::TYPE_LONG : cilp_pkg::TYPE_INT;
      end
      if (is_long) return lit_value[63] ? cilp_pkg::TYPE_ULONG : cilp_pkg::TYPE_LONG;
      if (is_unsigned)
         return (lit_value[63:32] != 0) ? cilp_pkg::TYPE_ULONG : cilp_pkg::TYPE_UINT;
      if (lit_value[63]) return cilp_pkg::TYPE_ULONG;
      if (lit_value[63:32] != 0) return cilp_pkg::TYPE_LONG;
      if (lit_value[63:31] != 0) return cilp_pkg::TYPE_UINT;
      return cilp_pkg::TYPE_INT;
   endfunction

   // Literal finished by character next_char
   function automatic void close_literal(logic [7:0] next_char);
      literal_type lit;
      lit.value         = lit_value;
      lit.type_code     = literal_kind();
      lit.length        = lit_len;
      lit.float_follows = next_char == "." || next_char == "e" || next_char == "E" ||
                          next_char == "f" || next_char == "F";
      expected_literals.push_back(lit);
      pending_literals++;
      clear_literal();
   endfunction

   function automatic void digit_or_suffix(logic [7:0] c);
      int d;
      d = digit_value(c, lit_radix);
      if (d >= 0) begin
         add_digit(d);
         count_char();
      end else if (is_l(c) || is_u(c)) begin
         seen_letters = {8'h00, c};
         count_char();
         lex_state = LEX_SUFFIX1;
      end else begin
         close_literal(c);
      end
   endfunction

   // One accepted character through the lexer
   function automatic void lex_char(logic [7:0] c, logic first);
      logic [7:0]          s0;
      logic [7:0]          s1;
      cilp_pkg::radix_type rx;
      int                  d;
      s0 = seen_letters[7:0];
      s1 = seen_letters[15:8];
      if (first) begin
         clear_literal();
         if (c == "0") begin
            lit_radix = cilp_pkg::RADIX_OCT;
            lit_len   = LENGTH_BITS'(1);
            lex_state = LEX_ZERO;
         end else if (c >= "1" && c <= "9") begin
            lit_value = 64'(c - "0");
            lit_len   = LENGTH_BITS'(1);
            lex_state = LEX_DIGITS;
         end else begin
            close_literal(c);
         end
         return;
      end
      case (lex_state)
         LEX_ZERO: begin
            if (c == "x" || c == "X") begin
               seen_letters = {8'h00, c};
               lex_state    = LEX_PREFIX_X;
            end else if (c == "b" || c == "B") begin
               seen_letters = {8'h00, c};
               lex_state    = LEX_PREFIX_B;
            end else begin
               lex_state = LEX_DIGITS;
               digit_or_suffix(c);
            end
         end
         LEX_PREFIX_X, LEX_PREFIX_B: begin
            rx = (lex_state == LEX_PREFIX_X) ? cilp_pkg::RADIX_HEX : cilp_pkg::RADIX_BIN;
            d  = digit_value(c, rx);
            // no digit after the prefix: octal 0, prefix letter follows it
            if (d < 0) begin
               close_literal(s0);
            end else begin
               lit_radix    = rx;
               lit_value    = 64'(d);
               lit_len      = LENGTH_BITS'(3);
               seen_letters = '0;
               lex_state    = LEX_DIGITS;
            end
         end
         LEX_DIGITS: digit_or_suffix(c);
         LEX_SUFFIX1: begin
            if (is_l(s0)) begin
               if (c == s0) begin
                  seen_letters = {c, s0};
                  count_char();
                  lex_state = LEX_SUFFIX2;
               end else if (is_u(c)) begin
                  is_long     = 1'b1;
                  is_unsigned = 1'b1;
                  count_char();
                  lex_state = LEX_DONE;
               end else begin
                  is_long = 1'b1;
                  close_literal(c);
               end
            end else if (is_l(c)) begin
               seen_letters = {c, s0};
               count_char();
               lex_state = LEX_SUFFIX2;
            end else begin
               is_unsigned = 1'b1;
               close_literal(c);
            end
         end
         LEX_SUFFIX2: begin
            if (is_l(s0)) begin
               if (is_u(c)) begin
                  is_long     = 1'b1;
                  is_unsigned = 1'b1;
                  count_char();
                  lex_state = LEX_DONE;
               end else begin
                  is_long = 1'b1;
                  close_literal(c);
               end
            end else begin
               // U then L: a third L must match the case of the second
               is_long     = 1'b1;
               is_unsigned = 1'b1;
               if (c == s1) begin
                  count_char();
                  lex_state = LEX_DONE;
               end else begin
                  close_literal(c);
               end
            end
         end
         LEX_DONE: close_literal(c);
         default: ;   // idle: character dropped
      endcase
   endfunction

   // Predict on req transfers, compare on rsp transfers
   always @(posedge clock) begin
      literal_type lit;
      literal_type got;
      if (reset) begin
         clear_literal();
         expected_literals.delete();
         pending_literals = 0;
         mismatch_count   = 0;
      end else begin
         if (req_tvalid && req_tready) lex_char(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            got.value         = rsp_tdata[63:0];
            got.type_code     = rsp_tdata[65:64];
            got.length        = rsp_tdata[65+LENGTH_BITS:66];
            got.float_follows = rsp_tdata[66+LENGTH_BITS];
            if (expected_literals.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected literal: value %h type %0d length %0d float %0b",
                           got.value, got.type_code, got.length, got.float_follows);
               mismatch_count++;
            end else begin
               lit = expected_literals.pop_front();
               pending_literals--;
               if (got.value !== lit.value || got.type_code !== lit.type_code ||
                   got.length !== lit.length || got.float_follows !== lit.float_follows) begin
                  if (mismatch_count < 10) begin
                     $display("literal mismatch: expected value %h type %0d length %0d float %0b",
                              lit.value, lit.type_code, lit.length, lit.float_follows);
                     $display("                  actual   value %h type %0d length %0d float %0b",
                              got.value, got.type_code, got.length, got.float_follows);
                  end
                  mismatch_count++;
               end
            end
         end
      end
   end

endmodule

// ===== tb/c_integer_literal_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// c_integer_literal_parser_unit_tb: drives character streams into the parser,
// with directed literals first and random ones after; verdict from the checker.
// Depends on c_integer_literal_parser_unit, cilp_pkg and cilp_literal_checker.
module c_integer_literal_parser_unit_tb;

   localparam int unsigned LENGTH_BITS = 12;
   localparam int unsigned RSP_BITS    = ((67 + LENGTH_BITS + 7) / 8) * 8;
   localparam int          STALL_LIMIT = 2000;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata  = '0;    // [7:0] char_code
   logic                req_tuser  = 1'b0;  // [0] first_char
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;          // value, type, length, float_follows

   int mismatch_count;
   int pending_literals;
   int stall_cycles = 0;
   int chars_sent   = 0;
   bit calm         = 1'b0;   // no idling on either side while set

   string term_chars = " ;,)+.eEfF]";
   string hex_digits = "0123456789abcdefABCDEF";
   string suffix_set [25] = '{"", "", "", "u", "U", "l", "L", "ul", "UL", "uL", "Lu",
                              "lU", "ll", "LL", "llu", "LLU", "ull", "ULL", "Ull",
                              "lL", "Ll", "uLl", "ULl", "llL", "lul"};

   always #5 clock = ~clock;

   c_integer_literal_parser_unit #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cilp_literal_checker #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .mismatch_count   (mismatch_count),
      .pending_literals (pending_literals)
   );

   // Result side backpressure
   always @(posedge clock) rsp_tready <= calm || ($urandom_range(99) >= 14);

   // Cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // One character transfer, with random idle cycles ahead of it
   task automatic send_char(input logic [7:0] c, input logic first);
      bit ready_seen;
      while (!calm && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= first;
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
      chars_sent++;
   endtask

   // First character flagged as the start of a literal
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
   endtask

   task automatic send_suffix(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   // Hold the sender until every predicted literal has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_literals != 0);
      @(posedge clock);
   endtask

   task automatic send_random_literal();
      int   pick;
      int   n;
      bit   wide;
      pick = $urandom_range(99);
      wide = ($urandom_range(4) == 0);
      // stray bytes with either flag: unflagged ones mostly dropped, flagged ones start literals
      if (pick < 8) begin
         n = $urandom_range(1, 4);
         repeat (n) send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
         return;
      end
      case ($urandom_range(3))
         0: begin
            send_char(8'("1" + $urandom_range(8)), 1'b1);
            n = wide ? $urandom_range(8, 21) : $urandom_range(0, 5);
            repeat (n) send_char(8'("0" + $urandom_range(9)), 1'b0);
         end
         1: begin
            send_char("0", 1'b1);
            n = wide ? $urandom_range(10, 23) : $urandom_range(0, 4);
            repeat (n) send_char(8'("0" + $urandom_range(7)), 1'b0);
         end
         2: begin
            send_char("0", 1'b1);
            send_char($urandom_range(1) ? "x" : "X", 1'b0);
            // prefix then a closing character, which may be a hex digit (e, E, f, F)
            if (pick < 12) begin
               send_char(term_chars[$urandom_range(term_chars.len() - 1)], 1'b0);
               return;
            end
            n = wide ? $urandom_range(8, 18) : $urandom_range(1, 6);
            repeat (n) send_char(hex_digits[$urandom_range(hex_digits.len() - 1)], 1'b0);
         end
         default: begin
            send_char("0", 1'b1);
            send_char($urandom_range(1) ? "b" : "B", 1'b0);
            if (pick < 12) begin
               send_char(8'("0" + $urandom_range(2, 9)), 1'b0);
               return;
            end
            n = wide ? $urandom_range(30, 66) : $urandom_range(1, 8);
            repeat (n) send_char(8'("0" + $urandom_range(1)), 1'b0);
         end
      endcase
      if ($urandom_range(3) != 0) send_suffix(suffix_set[$urandom_range(24)]);
      // no closing character: the next literal abandons this one
      if (pick < 14) return;
      if ($urandom_range(9) == 0) send_char(8'($urandom_range(255)), 1'b0);
      else send_char(term_chars[$urandom_range(term_chars.len() - 1)], 1'b0);
   endtask

   initial begin
      int literal_count;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: bases, prefixes, suffixes, type edges, float followers
      send_char("q", 1'b0);            // dropped while idle
      send_text("0 ");
      send_text("7;");
      send_text("0777)");
      send_text("08 ");
      send_text("0x1F ");
      send_text("0XaBu ");
      send_text("0b101L ");
      send_text("0B1ul ");
      send_text("0x ");                // prefix without digit
      send_text("0bz");
      send_text("2147483648 ");
      send_text("4294967296u ");
      send_text("0x80000000 ");
      send_text("0xffffffffffffffffL ");
      send_text("0x8000000000000000 ");
      send_text("18446744073709551616 ");
      send_text("1.5");
      send_text("2e");
      send_text("3E");
      send_text("4f");
      send_text("5F");
      send_text("1LLU ");
      send_text("1ull ");
      send_text("1lL ");
      send_text("1uLl ");
      send_text("1Lu ");
      send_text("12");                 // abandoned by the restart below
      send_text("34 ");
      send_text("x");
      send_text(".");
      send_char(8'hFF, 1'b1);
      wait_drained();

      // Random literals
      literal_count = 0;
      while (chars_sent < 600) begin
         calm = (chars_sent >= 250 && chars_sent < 400);
         send_random_literal();
         literal_count++;
         if (literal_count % 40 == 0) wait_drained();
      end
      calm = 1'b0;

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_literals == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
